/* src/kmu_pkg.sv */
// kmu_pkg: shared widths, command and register codes for the k-means core.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps
package kmu_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 64;
  localparam int COORD_BITS   = 16;

  localparam int CLUSTER_BITS = 4;
  localparam int DIM_BITS     = 6;
  localparam int ADDR_BITS    = CLUSTER_BITS + DIM_BITS;
  localparam int K_BITS       = 5;
  localparam int ND_BITS      = 7;
  localparam int CMD_BITS     = 2;
  localparam int PID_BITS     = 16;
  localparam int SUM_BITS     = 33;
  localparam int COUNT_BITS   = 16;
  localparam int DIST_BITS    = 38;
  localparam int SQ_BITS      = 2 * (COORD_BITS + 1);

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_POINT  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_CLUSTERS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_DIMS     = 1'd1;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

endpackage

/* src/kmu_in_if.sv */
// kmu_in_if: input item channel of the k-means core.
// Depends on kmu_pkg.
`timescale 1ns / 1ps
interface kmu_in_if;
  import kmu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_BITS-1:0]     cmd;
  logic [CLUSTER_BITS-1:0] cluster_sel;
  logic [DIM_BITS-1:0]     dim_index;
  logic [COORD_BITS-1:0]   value;
  logic [PID_BITS-1:0]     point_id;
  logic                    last;
  modport source (output valid, cmd, cluster_sel, dim_index, value, point_id, last,
                  input ready);
  modport sink (input valid, cmd, cluster_sel, dim_index, value, point_id, last,
                output ready);
endinterface

/* src/kmu_out_if.sv */
// kmu_out_if: result item channel of the k-means core.
// Depends on kmu_pkg.
`timescale 1ns / 1ps
interface kmu_out_if;
  import kmu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [PID_BITS-1:0]     point_tag;
  logic [CLUSTER_BITS-1:0] cluster;
  logic [DIST_BITS-1:0]    sq_distance;
  logic                    saturated;
  modport source (output valid, kind, point_tag, cluster, sq_distance, saturated,
                  input ready);
  modport sink (input valid, kind, point_tag, cluster, sq_distance, saturated,
                output ready);
endinterface

/* src/kmu_cfg_if.sv */
// kmu_cfg_if: register write channel of the k-means core.
// Depends on kmu_pkg.
`timescale 1ns / 1ps
interface kmu_cfg_if;
  import kmu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/kmeans_assign_and_update_core.sv */
// kmeans_assign_and_update_core: one Lloyd k-means iteration over memories.
// Load item: written to the centroid memory on accept. Point coordinate: 16 centroid
// reads, one per cycle through the centroid memory port, plus pipeline drain. Last
// coordinate adds a minimum search and a sum read-modify-write over nd dimensions.
// Update: sweeps all 1024 store entries; divided entries use a 33-step serial divider.
// After reset a clearing pass zeroes the centroid and sum memories; no item is taken.
`timescale 1ns / 1ps
module kmeans_assign_and_update_core (
  input logic       clk_i,
  input logic       rst_ni,
  kmu_in_if.sink    item_i,
  kmu_cfg_if.sink   cfg_i,
  kmu_out_if.source result_o
);
  import kmu_pkg::*;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DIST     = 4'd2;
  localparam logic [3:0] ST_MIN_INIT = 4'd3;
  localparam logic [3:0] ST_MIN      = 4'd4;
  localparam logic [3:0] ST_CHECK    = 4'd5;
  localparam logic [3:0] ST_ACC      = 4'd6;
  localparam logic [3:0] ST_PT_DONE  = 4'd7;
  localparam logic [3:0] ST_UPD_RD   = 4'd8;
  localparam logic [3:0] ST_UPD_EVAL = 4'd9;
  localparam logic [3:0] ST_UPD_DIV  = 4'd10;
  localparam logic [3:0] ST_UPD_WR   = 4'd11;
  localparam logic [3:0] ST_UPD_DONE = 4'd12;

  localparam logic [K_BITS-1:0]    K_MAX     = K_BITS'(MAX_CLUSTERS);
  localparam logic [ND_BITS-1:0]   ND_MAX    = ND_BITS'(MAX_DIMS);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_TOP  = {DIST_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] ADDR_TOP  = {ADDR_BITS{1'b1}};
  localparam logic [5:0]           DIV_LAST  = 6'(SUM_BITS - 1);

  logic [3:0] state_q, state_d;

  // configuration
  logic [K_BITS-1:0]  act_k_q;
  logic [ND_BITS-1:0] act_d_q;
  logic [K_BITS-1:0]  eff_k;
  logic [ND_BITS-1:0] eff_d;

  // memories
  logic [COORD_BITS-1:0] cent_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [SUM_BITS-1:0]   sum_mem  [MAX_CLUSTERS*MAX_DIMS];
  logic [COORD_BITS-1:0] pbuf_mem [MAX_DIMS];
  logic                  cent_we, sum_we, pbuf_we;
  logic [ADDR_BITS-1:0]  cent_wa, cent_ra, sum_wa, sum_ra;
  logic [COORD_BITS-1:0] cent_wd, cent_rd, pbuf_rd;
  logic [SUM_BITS-1:0]   sum_wd, sum_rd;
  logic [DIM_BITS-1:0]   pbuf_ra;

  // small register files
  logic [DIST_BITS-1:0]  dist_q  [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0] count_q [MAX_CLUSTERS];

  // latched item
  logic [COORD_BITS-1:0]   val_q;
  logic [DIM_BITS-1:0]     dim_q;
  logic                    last_q;
  logic [PID_BITS-1:0]     pid_q;

  // distance pipeline
  logic                    iss_q, p1_v_q, p2_v_q;
  logic [CLUSTER_BITS-1:0] rd_c_q, p1_c_q, p2_c_q;
  logic [SQ_BITS-1:0]      sq_q;
  logic [COORD_BITS:0]     diff, mag;
  logic [DIST_BITS:0]      dist_sum;

  // search / accumulate
  logic [CLUSTER_BITS-1:0] mc_q, best_q;
  logic [DIST_BITS-1:0]    bd_q;
  logic                    sat_q, sat_now;
  logic                    a_iss_q, a1_v_q;
  logic [DIM_BITS-1:0]     ad_q, a1_d_q;

  // update sweep and divider
  logic [ADDR_BITS-1:0]    idx_q;
  logic [CLUSTER_BITS-1:0] uc;
  logic [DIM_BITS-1:0]     ud;
  logic                    need_div;
  logic [SUM_BITS-1:0]     quo_q, sum_mag;
  logic [COUNT_BITS-1:0]   rem_q;
  logic [COUNT_BITS:0]     trial;
  logic                    neg_q;
  logic [5:0]              dcnt_q;
  logic [COORD_BITS-1:0]   mean;

  // output register
  logic                    out_valid_q;
  logic                    out_kind_q, out_sat_q;
  logic [PID_BITS-1:0]     out_tag_q;
  logic [CLUSTER_BITS-1:0] out_cl_q;
  logic [DIST_BITS-1:0]    out_dist_q;
  logic                    out_free, in_acc;

  // Registers out of range clamp into 1..max.
  always_comb begin
    if (act_k_q == '0) eff_k = K_BITS'(1);
    else if (act_k_q > K_MAX) eff_k = K_MAX;
    else eff_k = act_k_q;
    if (act_d_q == '0) eff_d = ND_BITS'(1);
    else if (act_d_q > ND_MAX) eff_d = ND_MAX;
    else eff_d = act_d_q;
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !out_valid_q || result_o.ready;

  assign result_o.valid       = out_valid_q;
  assign result_o.kind        = out_kind_q;
  assign result_o.point_tag   = out_tag_q;
  assign result_o.cluster     = out_cl_q;
  assign result_o.sq_distance = out_dist_q;
  assign result_o.saturated   = out_sat_q;

  // datapath pieces
  assign diff     = {val_q[COORD_BITS-1], val_q} - {cent_rd[COORD_BITS-1], cent_rd};
  assign mag      = diff[COORD_BITS] ? -diff : diff;
  assign dist_sum = {1'b0, dist_q[p2_c_q]} + (DIST_BITS+1)'(sq_q);
  assign uc       = idx_q[ADDR_BITS-1:DIM_BITS];
  assign ud       = idx_q[DIM_BITS-1:0];
  assign need_div = ({1'b0, uc} < eff_k) && ({1'b0, ud} < eff_d) && (count_q[uc] != '0);
  assign sum_mag  = sum_rd[SUM_BITS-1] ? -sum_rd : sum_rd;
  assign trial    = {rem_q, quo_q[SUM_BITS-1]};
  assign mean     = neg_q ? -quo_q[COORD_BITS-1:0] : quo_q[COORD_BITS-1:0];
  assign sat_now  = (count_q[best_q] == COUNT_TOP);

  // memory port steering
  always_comb begin
    cent_we = 1'b0;
    cent_wa = idx_q;
    cent_wd = '0;
    cent_ra = {rd_c_q, dim_q};
    sum_we  = 1'b0;
    sum_wa  = idx_q;
    sum_wd  = '0;
    sum_ra  = idx_q;
    pbuf_we = 1'b0;
    pbuf_ra = ad_q;
    unique case (state_q)
      ST_CLEAR: begin
        cent_we = 1'b1;
        sum_we  = 1'b1;
      end
      ST_IDLE: begin
        if (in_acc && item_i.cmd == CMD_LOAD) begin
          cent_we = 1'b1;
          cent_wa = {item_i.cluster_sel, item_i.dim_index};
          cent_wd = item_i.value;
        end
        pbuf_we = in_acc && item_i.cmd == CMD_POINT && ({1'b0, item_i.dim_index} < eff_d);
      end
      ST_ACC: begin
        sum_ra = {best_q, ad_q};
        sum_wa = {best_q, a1_d_q};
        sum_we = a1_v_q;
        sum_wd = sum_rd + {{(SUM_BITS-COORD_BITS){pbuf_rd[COORD_BITS-1]}}, pbuf_rd};
      end
      ST_UPD_EVAL: sum_we = !need_div;
      ST_UPD_WR: begin
        sum_we  = 1'b1;
        cent_we = 1'b1;
        cent_wd = mean;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cent_we) cent_mem[cent_wa] <= cent_wd;
    cent_rd <= cent_mem[cent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pbuf_we) pbuf_mem[item_i.dim_index] <= item_i.value;
    pbuf_rd <= pbuf_mem[pbuf_ra];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (idx_q == ADDR_TOP) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (item_i.cmd)
            CMD_POINT: begin
              if ({1'b0, item_i.dim_index} < eff_d) state_d = ST_DIST;
              else if (item_i.last) state_d = ST_MIN_INIT;
            end
            CMD_UPDATE: state_d = ST_UPD_RD;
            default: ;
          endcase
        end
      end
      ST_DIST:     if (!iss_q && !p1_v_q && !p2_v_q) state_d = last_q ? ST_MIN_INIT : ST_IDLE;
      ST_MIN_INIT: state_d = ST_MIN;
      ST_MIN:      if ({1'b0, mc_q} >= eff_k - K_BITS'(1)) state_d = ST_CHECK;
      ST_CHECK:    state_d = sat_now ? ST_PT_DONE : ST_ACC;
      ST_ACC:      if (!a_iss_q && !a1_v_q) state_d = ST_PT_DONE;
      ST_PT_DONE:  if (out_free) state_d = ST_IDLE;
      ST_UPD_RD:   state_d = ST_UPD_EVAL;
      ST_UPD_EVAL: begin
        if (need_div) state_d = ST_UPD_DIV;
        else state_d = (idx_q == ADDR_TOP) ? ST_UPD_DONE : ST_UPD_RD;
      end
      ST_UPD_DIV:  if (dcnt_q == DIV_LAST) state_d = ST_UPD_WR;
      ST_UPD_WR:   state_d = (idx_q == ADDR_TOP) ? ST_UPD_DONE : ST_UPD_RD;
      ST_UPD_DONE: if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      act_k_q     <= K_MAX;
      act_d_q     <= ND_MAX;
      idx_q       <= '0;
      iss_q       <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      a_iss_q     <= 1'b0;
      a1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        dist_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_ACTIVE_CLUSTERS: act_k_q <= cfg_i.data[K_BITS-1:0];
          REG_ACTIVE_DIMS:     act_d_q <= cfg_i.data[ND_BITS-1:0];
          default: ;
        endcase
      end

      // result register: load a finished result, else drop on accept
      if ((state_q == ST_PT_DONE || state_q == ST_UPD_DONE) && out_free) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;

      // distance pipeline: read, square, accumulate
      p1_v_q <= iss_q && state_q == ST_DIST;
      p2_v_q <= p1_v_q;
      if (iss_q && state_q == ST_DIST) begin
        if (rd_c_q == CLUSTER_BITS'(MAX_CLUSTERS - 1)) iss_q <= 1'b0;
      end
      if (p2_v_q) dist_q[p2_c_q] <= dist_sum[DIST_BITS] ? DIST_TOP : dist_sum[DIST_BITS-1:0];

      // accumulate pipeline
      a1_v_q <= a_iss_q && state_q == ST_ACC;
      if (a_iss_q && state_q == ST_ACC && {1'b0, ad_q} == eff_d - ND_BITS'(1)) a_iss_q <= 1'b0;

      unique case (state_q)
        ST_CLEAR: idx_q <= idx_q + ADDR_BITS'(1);
        ST_IDLE: begin
          if (in_acc && item_i.cmd == CMD_POINT) iss_q <= 1'b1;
          if (in_acc && item_i.cmd == CMD_UPDATE) idx_q <= '0;
        end
        ST_CHECK: a_iss_q <= !sat_now;
        ST_PT_DONE: begin
          if (out_free) begin
            if (!sat_q) count_q[best_q] <= count_q[best_q] + COUNT_BITS'(1);
            for (int i = 0; i < MAX_CLUSTERS; i++) dist_q[i] <= '0;
          end
        end
        ST_UPD_EVAL: if (!need_div) idx_q <= idx_q + ADDR_BITS'(1);
        ST_UPD_WR:   idx_q <= idx_q + ADDR_BITS'(1);
        ST_UPD_DONE: begin
          if (out_free) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
              dist_q[i]  <= '0;
              count_q[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q  <= item_i.value;
      dim_q  <= item_i.dim_index;
      last_q <= item_i.last;
      pid_q  <= item_i.point_id;
      rd_c_q <= '0;
    end else if (iss_q && state_q == ST_DIST) begin
      rd_c_q <= rd_c_q + CLUSTER_BITS'(1);
    end
    p1_c_q <= rd_c_q;
    p2_c_q <= p1_c_q;
    sq_q   <= SQ_BITS'(mag) * SQ_BITS'(mag);

    unique case (state_q)
      ST_MIN_INIT: begin
        best_q <= '0;
        bd_q   <= dist_q[0];
        mc_q   <= CLUSTER_BITS'(1);
      end
      ST_MIN: begin
        // strict compare: lowest index wins ties
        if ({1'b0, mc_q} < eff_k && dist_q[mc_q] < bd_q) begin
          best_q <= mc_q;
          bd_q   <= dist_q[mc_q];
        end
        mc_q <= mc_q + CLUSTER_BITS'(1);
      end
      ST_CHECK: begin
        sat_q <= sat_now;
        ad_q  <= '0;
      end
      ST_ACC: if (a_iss_q) ad_q <= ad_q + DIM_BITS'(1);
      ST_PT_DONE: begin
        if (out_free) begin
          out_kind_q <= KIND_ASSIGN;
          out_tag_q  <= pid_q;
          out_cl_q   <= best_q;
          out_dist_q <= bd_q;
          out_sat_q  <= sat_q;
        end
      end
      ST_UPD_EVAL: begin
        neg_q  <= sum_rd[SUM_BITS-1];
        quo_q  <= sum_mag;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      ST_UPD_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (trial >= {1'b0, count_q[uc]}) begin
          rem_q <= COUNT_BITS'(trial - {1'b0, count_q[uc]});
          quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
        end else begin
          rem_q <= trial[COUNT_BITS-1:0];
          quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 6'd1;
      end
      ST_UPD_DONE: begin
        if (out_free) begin
          out_kind_q <= KIND_UPDATE;
          out_tag_q  <= '0;
          out_cl_q   <= '0;
          out_dist_q <= '0;
          out_sat_q  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_iss_q) a1_d_q <= ad_q;
  end

endmodule
